// ----- hdl/bc1_pkg.sv -----
// shared types, constants and helpers for the bc1 colour block decoder
package bc1_pkg;

  // rgb565 channel layout
  localparam logic [15:0] RED_MASK   = 16'hf800;
  localparam logic [15:0] GREEN_MASK = 16'h07e0;
  localparam logic [15:0] BLUE_MASK  = 16'h001f;
  localparam int unsigned RED_POS    = 11;
  localparam int unsigned GREEN_POS  = 5;
  localparam int unsigned BLUE_POS   = 0;

  // channel slots inside the per-channel sum arrays
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned NUM_CH   = 3;

  // reciprocal of three for sums below 256: floor(x/3) = (x*171) >> 9
  localparam logic [7:0] RECIP3     = 8'd171;
  localparam int unsigned RECIP3_SH = 9;

  localparam logic [1:0] LAST_ROW = 2'd3;

  // one block request
  typedef struct packed {
    logic [15:0] color0;
    logic [15:0] color1;
    logic [31:0] index_bits;
  } bc1_in_t;

  // one decoded row
  typedef struct packed {
    logic [1:0]  row_number;
    logic [15:0] pixel0;
    logic [15:0] pixel1;
    logic [15:0] pixel2;
    logic [15:0] pixel3;
    logic        last_row;
  } bc1_out_t;

  // four-entry palette with the indices of its block
  typedef struct packed {
    logic [3:0][15:0] entry;
    logic [31:0]      index_bits;
  } bc1_pal_t;

  // floor of a narrow sum divided by three
  function automatic logic [5:0] div3(input logic [7:0] x);
    logic [15:0] prod;
    begin
      prod = 16'(x) * 16'(RECIP3);
      div3 = prod[RECIP3_SH +: 6];
    end
  endfunction

endpackage

// ----- hdl/bc1_pal.sv -----
// two-stage palette builder: channel sums, then division and entry selection
module bc1_pal (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bc1_pkg::bc1_in_t in_data,
  output logic             pal_valid,
  input  logic             pal_ready,
  output bc1_pkg::bc1_pal_t pal_data
);
  import bc1_pkg::*;

  // stage one registers
  logic                  v1;
  logic                  gt1;
  logic [15:0]           c0_1;
  logic [15:0]           c1_1;
  logic [31:0]           idx1;
  logic [NUM_CH-1:0][7:0] mix2;
  logic [NUM_CH-1:0][7:0] mix3;
  logic [NUM_CH-1:0][7:0] avg;

  // stage two registers
  logic     v2;
  bc1_pal_t pal2;

  logic ready1;
  logic ready2;

  logic [NUM_CH-1:0][7:0] ca;
  logic [NUM_CH-1:0][7:0] cb;
  logic [NUM_CH-1:0][7:0] mix2_next;
  logic [NUM_CH-1:0][7:0] mix3_next;
  logic [NUM_CH-1:0][7:0] avg_next;

  logic [NUM_CH-1:0][5:0] q2;
  logic [NUM_CH-1:0][5:0] q3;
  logic [15:0]            e2_next;
  logic [15:0]            e3_next;

  assign ready2   = !v2 || pal_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // split endpoints into channels
  always_comb begin
    ca[CH_RED]   = 8'((in_data.color0 & RED_MASK) >> RED_POS);
    ca[CH_GREEN] = 8'((in_data.color0 & GREEN_MASK) >> GREEN_POS);
    ca[CH_BLUE]  = 8'((in_data.color0 & BLUE_MASK) >> BLUE_POS);
    cb[CH_RED]   = 8'((in_data.color1 & RED_MASK) >> RED_POS);
    cb[CH_GREEN] = 8'((in_data.color1 & GREEN_MASK) >> GREEN_POS);
    cb[CH_BLUE]  = 8'((in_data.color1 & BLUE_MASK) >> BLUE_POS);
    for (int i = 0; i < NUM_CH; i++) begin
      mix2_next[i] = (ca[i] << 1) + cb[i] + 8'd1;
      mix3_next[i] = ca[i] + (cb[i] << 1) + 8'd1;
      avg_next[i]  = ca[i] + cb[i];
    end
  end

  // stage one: weighted sums and endpoint compare
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
    if (ready1 && in_valid) begin
      gt1  <= in_data.color0 > in_data.color1;
      c0_1 <= in_data.color0;
      c1_1 <= in_data.color1;
      idx1 <= in_data.index_bits;
      mix2 <= mix2_next;
      mix3 <= mix3_next;
      avg  <= avg_next;
    end
  end

  // divide by three and pick the middle entries
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      q2[i] = div3(mix2[i]);
      q3[i] = div3(mix3[i]);
    end
    if (gt1) begin
      e2_next = {q2[CH_RED][4:0], q2[CH_GREEN][5:0], q2[CH_BLUE][4:0]};
      e3_next = {q3[CH_RED][4:0], q3[CH_GREEN][5:0], q3[CH_BLUE][4:0]};
    end else begin
      e2_next = {avg[CH_RED][5:1], avg[CH_GREEN][6:1], avg[CH_BLUE][5:1]};
      e3_next = 16'd0;
    end
  end

  // stage two: finished palette
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
    if (ready2 && v1) begin
      pal2.entry[0]    <= c0_1;
      pal2.entry[1]    <= c1_1;
      pal2.entry[2]    <= e2_next;
      pal2.entry[3]    <= e3_next;
      pal2.index_bits  <= idx1;
    end
  end

  assign pal_valid = v2;
  assign pal_data  = pal2;

endmodule

// ----- hdl/bc1_row_ser.sv -----
// row serialiser: holds one palette and issues its four rows through an output register
module bc1_row_ser (
  input  logic              clk,
  input  logic              rst,
  input  logic              pal_valid,
  output logic              pal_ready,
  input  bc1_pkg::bc1_pal_t pal_data,
  output logic              row_valid,
  input  logic              row_ready,
  output bc1_pkg::bc1_out_t row_data
);
  import bc1_pkg::*;

  logic     busy;
  logic     busy_next;
  bc1_pal_t held;
  logic [1:0] row_cnt;
  logic       out_v;
  bc1_out_t   out_reg;

  logic       load;
  logic [7:0] row_bits;
  bc1_out_t   row_next;

  // a row moves into the output register when it is free or being taken
  assign load      = busy && (!out_v || row_ready);
  assign pal_ready = !busy || (load && row_cnt == LAST_ROW);

  always_comb begin
    busy_next = busy;
    if (load && row_cnt == LAST_ROW) begin
      busy_next = 1'b0;
    end
    if (pal_valid && pal_ready) begin
      busy_next = 1'b1;
    end
  end

  // look up the four pixels of the current row
  always_comb begin
    row_bits            = held.index_bits[{row_cnt, 3'b000} +: 8];
    row_next.row_number = row_cnt;
    row_next.pixel0     = held.entry[row_bits[1:0]];
    row_next.pixel1     = held.entry[row_bits[3:2]];
    row_next.pixel2     = held.entry[row_bits[5:4]];
    row_next.pixel3     = held.entry[row_bits[7:6]];
    row_next.last_row   = row_cnt == LAST_ROW;
  end

  // palette hold and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      row_cnt <= 2'd0;
    end else begin
      busy <= busy_next;
      if (pal_valid && pal_ready) begin
        row_cnt <= 2'd0;
      end else if (load) begin
        row_cnt <= row_cnt + 2'd1;
      end
    end
    if (pal_valid && pal_ready) begin
      held <= pal_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (load) begin
      out_v <= 1'b1;
    end else if (row_ready) begin
      out_v <= 1'b0;
    end
    if (load) begin
      out_reg <= row_next;
    end
  end

  assign row_valid = out_v;
  assign row_data  = out_reg;

endmodule

// ----- hdl/bc1_color_block_decoder_top.sv -----
// top level of the bc1 colour block decoder
//
// usage:
//   blk channel: one request per 64-bit bc1 colour block (two rgb565
//   endpoints and 32 bits of 2-bit indices), valid/ready handshake.
//   row channel: four requests per block, top row first, each with four
//   rgb565 pixels, the row number and a flag on the fourth row.
// path: row 0 is registered after the block crosses both palette stages;
//   rows 1 to 3 follow one per cycle while the receiver takes them.
// throughput: the single row channel issues four rows per block and sets the
//   block rate; the two palette stages accept a new block each cycle while
//   not stalled and hold up to two blocks ahead of the serialiser, which
//   takes the next block in the cycle its last row is issued.
// reset: synchronous, clears every valid bit; no block is in flight after it.
// stalls: when row_ready is low the output row is held and the stages
//   behind it fill and then drop blk_ready; nothing is lost or repeated.
module bc1_color_block_decoder_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              blk_valid,
  output logic              blk_ready,
  input  bc1_pkg::bc1_in_t  blk_data,
  output logic              row_valid,
  input  logic              row_ready,
  output bc1_pkg::bc1_out_t row_data
);
  import bc1_pkg::*;

  logic     pal_valid;
  logic     pal_ready;
  bc1_pal_t pal_data;

  // palette construction
  bc1_pal u_pal (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (blk_valid),
    .in_ready  (blk_ready),
    .in_data   (blk_data),
    .pal_valid (pal_valid),
    .pal_ready (pal_ready),
    .pal_data  (pal_data)
  );

  // row issue
  bc1_row_ser u_row_ser (
    .clk       (clk),
    .rst       (rst),
    .pal_valid (pal_valid),
    .pal_ready (pal_ready),
    .pal_data  (pal_data),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row_data  (row_data)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the bc1 colour block decoder: random blocks, random stalls
module tb;
  import bc1_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_BLOCKS = 500;
  localparam int unsigned MAX_REPORTS = 10;

  // predicts the four decoded rows of each block and checks them in order
  class bc1_row_tracker;
    bc1_out_t expected_rows[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function int unsigned pending();
      return expected_rows.size();
    endfunction

    // one rgb565 channel of a weighted endpoint blend
    function logic [15:0] channel_mix(logic [15:0] a, logic [15:0] b, logic [15:0] mask,
                                      int unsigned pos, int unsigned wa, int unsigned wb,
                                      int unsigned bias, int unsigned dv);
      int unsigned ca;
      int unsigned cb;
      int unsigned v;
      ca = int'((a & mask) >> pos);
      cb = int'((b & mask) >> pos);
      v = (ca * wa + cb * wb + bias) / dv;
      return 16'(v << pos) & mask;
    endfunction

    function logic [15:0] blend_565(logic [15:0] a, logic [15:0] b, int unsigned wa,
                                    int unsigned wb, int unsigned bias, int unsigned dv);
      return channel_mix(a, b, RED_MASK, RED_POS, wa, wb, bias, dv)
           | channel_mix(a, b, GREEN_MASK, GREEN_POS, wa, wb, bias, dv)
           | channel_mix(a, b, BLUE_MASK, BLUE_POS, wa, wb, bias, dv);
    endfunction

    // build the palette and queue the four rows of an accepted block
    function void take_block(bc1_in_t blk);
      logic [15:0] palette [4];
      logic [7:0] row_bits;
      bc1_out_t row;
      palette[0] = blk.color0;
      palette[1] = blk.color1;
      if (blk.color0 > blk.color1) begin
        palette[2] = blend_565(blk.color0, blk.color1, 2, 1, 1, 3);
        palette[3] = blend_565(blk.color0, blk.color1, 1, 2, 1, 3);
      end else begin
        palette[2] = blend_565(blk.color0, blk.color1, 1, 1, 0, 2);
        palette[3] = 16'h0000;
      end
      for (int r = 0; r < 4; r++) begin
        row_bits = blk.index_bits[8*r +: 8];
        row.row_number = 2'(r);
        row.pixel0 = palette[row_bits[1:0]];
        row.pixel1 = palette[row_bits[3:2]];
        row.pixel2 = palette[row_bits[5:4]];
        row.pixel3 = palette[row_bits[7:6]];
        row.last_row = (row.row_number == LAST_ROW);
        expected_rows.push_back(row);
      end
    endfunction

    function void compare_field(string field, logic [15:0] exp_val, logic [15:0] act_val);
      if (exp_val !== act_val) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("mismatch on %s: expected %h, got %h", field, exp_val, act_val);
      end
    endfunction

    // compare one accepted row with the oldest prediction
    function void check_row(bc1_out_t got);
      bc1_out_t exp_row;
      if (expected_rows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected row: got %h with nothing pending", got);
        return;
      end
      exp_row = expected_rows.pop_front();
      compare_field("row_number", 16'(exp_row.row_number), 16'(got.row_number));
      compare_field("pixel0", exp_row.pixel0, got.pixel0);
      compare_field("pixel1", exp_row.pixel1, got.pixel1);
      compare_field("pixel2", exp_row.pixel2, got.pixel2);
      compare_field("pixel3", exp_row.pixel3, got.pixel3);
      compare_field("last_row", 16'(exp_row.last_row), 16'(got.last_row));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic blk_valid = 1'b0;
  logic blk_ready;
  bc1_in_t blk_data = '0;
  logic row_valid;
  logic row_ready = 1'b0;
  bc1_out_t row_data;

  bc1_row_tracker tracker = new();
  int unsigned cycle_count = 0;

  // gap state per side: stretches of calm or of random waits, each kind picked at random
  int unsigned send_left = 0;
  bit send_calm = 1'b0;
  int unsigned recv_left = 0;
  bit recv_calm = 1'b0;

  bc1_color_block_decoder_top i_dut (
    .clk(clk),
    .rst(rst),
    .blk_valid(blk_valid),
    .blk_ready(blk_ready),
    .blk_data(blk_data),
    .row_valid(row_valid),
    .row_ready(row_ready),
    .row_data(row_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned next_gap(inout int unsigned left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(8, 40);
      calm = ($urandom_range(0, 2) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // random block: mostly free endpoints, some equal, some at channel extremes
  function automatic bc1_in_t random_block();
    bc1_in_t blk;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    blk.color0 = 16'($urandom);
    blk.color1 = 16'($urandom);
    blk.index_bits = $urandom;
    if (pick == 0) begin
      blk.color1 = blk.color0;
    end else if (pick == 1) begin
      blk.color0 = {{5{1'($urandom)}}, {6{1'($urandom)}}, {5{1'($urandom)}}};
      blk.color1 = {{5{1'($urandom)}}, {6{1'($urandom)}}, {5{1'($urandom)}}};
    end
    return blk;
  endfunction

  // present one block after a gap and wait for it to be taken
  task automatic send_block(input bc1_in_t blk);
    int unsigned gap;
    gap = next_gap(send_left, send_calm);
    @(negedge clk);
    if (gap > 0) begin
      blk_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    blk_valid <= 1'b1;
    blk_data <= blk;
    do @(posedge clk); while (!blk_ready);
    tracker.take_block(blk);
  endtask

  // hold off new blocks until every predicted row has come out
  task automatic drain_rows();
    @(negedge clk);
    blk_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // row receiver with random stalls
  initial begin
    int unsigned stall;
    @(negedge rst);
    forever begin
      stall = next_gap(recv_left, recv_calm);
      @(negedge clk);
      if (stall > 0) begin
        row_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      row_ready <= 1'b1;
      do @(posedge clk); while (!row_valid);
      tracker.check_row(row_data);
    end
  end

  initial begin
    bc1_in_t directed [$];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // endpoint order, equal endpoints, channel extremes and index patterns
    directed.push_back('{16'hffff, 16'h0000, 32'he4e4e4e4});
    directed.push_back('{16'h0000, 16'hffff, 32'he4e4e4e4});
    directed.push_back('{16'h1234, 16'h1234, 32'he4e4e4e4});
    directed.push_back('{16'hffff, 16'hffff, 32'h1b1b1b1b});
    directed.push_back('{16'h0000, 16'h0000, 32'hffffffff});
    directed.push_back('{16'h8001, 16'h8000, 32'h1b6ce4b1});
    directed.push_back('{16'h8000, 16'h8001, 32'h1b6ce4b1});
    directed.push_back('{16'hf800, 16'h07e0, 32'h00000000});
    directed.push_back('{16'h07e0, 16'h001f, 32'hffffffff});
    directed.push_back('{16'h001f, 16'hf800, 32'h55555555});
    directed.push_back('{16'hf800, 16'h001f, 32'haaaaaaaa});
    directed.push_back('{16'h07e0, 16'hf81f, 32'hffffffff});
    directed.push_back('{16'hffdf, 16'h0020, 32'haaaaaaaa});
    directed.push_back('{16'h5aa5, 16'ha55a, 32'he4b11b4e});
    directed.push_back('{16'ha55a, 16'h5aa5, 32'he4b11b4e});
    directed.push_back('{16'h0001, 16'h0000, 32'hffffffff});
    foreach (directed[k]) send_block(directed[k]);
    drain_rows();

    // random blocks, with one full drain halfway
    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      send_block(random_block());
      if (n == RANDOM_BLOCKS / 2) drain_rows();
    end
    @(negedge clk);
    blk_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bc1_pkg.sv
hdl/bc1_pal.sv
hdl/bc1_row_ser.sv
hdl/bc1_color_block_decoder_top.sv
verif/tb.sv
